FILE: src/wbs_pkg.sv
// ============================================================================
// White blob steering package
// Shared widths, constants, types and the sequencer states of the block.
// ============================================================================
package wbs_pkg;

  // Item field widths.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned COL_W  = 11;
  localparam int unsigned ROW_W  = 13;
  localparam int unsigned LOC_W  = 13;
  localparam int unsigned MID_W  = 12;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned MAG_W  = 15;

  // Columns at or beyond this limit take no part in detection.
  localparam int unsigned MAX_COLS  = 2048;
  localparam int unsigned COL_CMP_W = 13;

  localparam logic [CHAN_W-1:0] CHAN_FULL       = 8'hFF;
  localparam logic [ROW_W-1:0]  ROW_BYTES_RESET = 13'd2400;

  // 3.142 in Q3.12, rounded.
  localparam logic signed [SPD_W-1:0] STRAIGHT_Q = 16'sd12870;
  localparam logic [MAG_W-1:0]        SAT_MAX    = 15'h7FFF;

  // Angular scale 3142/1000.
  localparam int unsigned ANG_MUL_W = 12;
  localparam int unsigned ANG_DIV_W = 10;
  localparam logic [ANG_MUL_W-1:0] ANG_MUL = 12'd3142;
  localparam logic [ANG_DIV_W-1:0] ANG_DIV = 10'd1000;
  localparam int unsigned PROD_W  = LOC_W + ANG_MUL_W;   // d * 3142
  localparam int unsigned MDEN_W  = MID_W + ANG_DIV_W;   // mid * 1000
  localparam int unsigned Q_SHIFT = 13;                  // 2 * 4096

  // Shared divider geometry.
  localparam int unsigned DIV_NUM_W = PROD_W + Q_SHIFT;
  localparam int unsigned DIV_DEN_W = MDEN_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Width of the region comparisons (20 * location).
  localparam int unsigned CMP_W = 18;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [COL_W-1:0]  column;
    logic              last_in_row;
    logic              last_in_frame;
  } pix_t;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic             found;
  } trk_snap_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] quo_sat;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_CENTRE,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_TURN_GO,
    S_TURN_WAIT,
    S_ANG_GO,
    S_ANG_WAIT,
    S_LOAD
  } state_t;

endpackage

FILE: src/wbs_in_if.sv
// ============================================================================
// Pixel input channel
// Valid/ready channel carrying one RGB pixel item with its position marks.
// ============================================================================
interface wbs_in_if;
  logic                         valid;
  logic                         ready;
  logic [wbs_pkg::CHAN_W-1:0]   red;
  logic [wbs_pkg::CHAN_W-1:0]   green;
  logic [wbs_pkg::CHAN_W-1:0]   blue;
  logic [wbs_pkg::COL_W-1:0]    column;
  logic                         last_in_row;
  logic                         last_in_frame;

  modport source (
    output valid, red, green, blue, column, last_in_row, last_in_frame,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, column, last_in_row, last_in_frame,
    output ready
  );
endinterface

FILE: src/wbs_out_if.sv
// ============================================================================
// Steering command channel
// Valid/ready channel carrying one steering command item per frame.
// ============================================================================
interface wbs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wbs_pkg::SPD_W-1:0]  linear_speed;
  logic signed [wbs_pkg::SPD_W-1:0]  angular_speed;
  logic                              ball_seen;

  modport source (
    output valid, linear_speed, angular_speed, ball_seen,
    input  ready
  );

  modport sink (
    input  valid, linear_speed, angular_speed, ball_seen,
    output ready
  );
endinterface

FILE: src/white_blob_steering.sv
// ============================================================================
// White blob steering
// Finds a white blob in an RGB pixel stream and issues one steering command
// per frame.
// ============================================================================
// Pixels are taken one item per clock while the block is idle. A pixel
// without the frame-end mark produces no result and the block is ready
// again in the next cycle. The final pixel of a frame starts the command
// computation, and in_ch.ready stays low until the block is idle again. The
// shared 38-step restoring divider runs twice (once for the turn ratio and
// once for the angular magnitude); set-up states prepare the operands
// (S_PREP), form the products (S_MUL) and start each division (S_TURN_GO,
// S_ANG_GO), each pass ends when its done flag is seen, and S_LOAD loads
// the output register. The command item then waits in that register until
// it is taken, while the block already accepts pixels of the next frame. If
// the previous command has still not been taken when the next one is ready,
// the block stays in its load step, with the input held off, until it is.
// The row width register is written from cfg_wdata with cfg_we and resets to
// 2400 bytes; it should only be changed while no command is being computed.
module white_blob_steering (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wbs_pkg::ROW_W-1:0]   cfg_wdata,
  wbs_in_if.sink                      in_ch,
  wbs_out_if.source                   out_ch
);

  // Configuration register: bytes per row.
  logic [wbs_pkg::ROW_W-1:0] row_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= wbs_pkg::ROW_BYTES_RESET;
    end else if (cfg_we) begin
      row_bytes_r <= cfg_wdata;
    end
  end

  // Pixel tracking.
  wbs_pkg::pix_t      pix;
  wbs_pkg::trk_snap_t snap;
  logic               in_acc;

  assign pix.red           = in_ch.red;
  assign pix.green         = in_ch.green;
  assign pix.blue          = in_ch.blue;
  assign pix.column        = in_ch.column;
  assign pix.last_in_row   = in_ch.last_in_row;
  assign pix.last_in_frame = in_ch.last_in_frame;
  assign in_acc            = in_ch.valid && in_ch.ready;

  wbs_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .pix    (pix),
    .snap   (snap)
  );

  // Sequencer state and the command datapath registers.
  wbs_pkg::state_t state_r, state_nxt;

  logic [wbs_pkg::LOC_W-1:0]  loc_r;
  logic                       found_r;
  logic [wbs_pkg::LOC_W-1:0]  d_r;
  logic [wbs_pkg::MID_W-1:0]  mid_r;
  logic                       zero_mid_r;
  wbs_pkg::dir_t              dir_r;
  logic                       far_r;
  logic [wbs_pkg::PROD_W-1:0] ang_prod_r;
  logic [wbs_pkg::MDEN_W-1:0] ang_den_r;
  logic [wbs_pkg::MAG_W-1:0]  turn_r;
  logic [wbs_pkg::MAG_W-1:0]  angm_r;

  wbs_pkg::div_req_t div_req;
  wbs_pkg::div_rsp_t div_rsp;

  logic out_valid_r;
  logic load_out;

  wbs_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wbs_pkg::S_IDLE: begin
        if (in_acc && in_ch.last_in_frame) begin
          state_nxt = wbs_pkg::S_PREP;
        end
      end
      wbs_pkg::S_PREP:    state_nxt = wbs_pkg::S_MUL;
      wbs_pkg::S_MUL:     state_nxt = wbs_pkg::S_TURN_GO;
      wbs_pkg::S_TURN_GO: state_nxt = wbs_pkg::S_TURN_WAIT;
      wbs_pkg::S_TURN_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = wbs_pkg::S_ANG_GO;
        end
      end
      wbs_pkg::S_ANG_GO:  state_nxt = wbs_pkg::S_ANG_WAIT;
      wbs_pkg::S_ANG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = wbs_pkg::S_LOAD;
        end
      end
      wbs_pkg::S_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = wbs_pkg::S_IDLE;
        end
      end
      default: state_nxt = wbs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs. The turn division is (2*d*4096 + mid) / (2*mid) and
  // the angular one is (2*d*4096*3142 + mid*1000) / (2*mid*1000), which
  // gives round-half-up quotients.
  always_comb begin
    in_ch.ready   = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = wbs_pkg::DIV_NUM_W'({ang_prod_r, wbs_pkg::Q_SHIFT'(0)}) +
                    wbs_pkg::DIV_NUM_W'(ang_den_r);
    div_req.den   = {ang_den_r, 1'b0};
    load_out      = 1'b0;
    unique case (state_r)
      wbs_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      wbs_pkg::S_TURN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = wbs_pkg::DIV_NUM_W'({d_r, wbs_pkg::Q_SHIFT'(0)}) +
                        wbs_pkg::DIV_NUM_W'(mid_r);
        div_req.den   = wbs_pkg::DIV_DEN_W'({mid_r, 1'b0});
      end
      wbs_pkg::S_ANG_GO: begin
        div_req.start = 1'b1;
      end
      wbs_pkg::S_LOAD: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wbs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Region tests, all as exact integer comparisons on L and R:
  // centred when 9R <= 20L <= 11R, left when 2L < R, right when 2L > R,
  // and beyond the outer band when 10L < 3R (left) or 10L > 7R (right).
  logic [wbs_pkg::CMP_W-1:0]   l_x, r_x;
  logic [wbs_pkg::CMP_W-1:0]   l20, l10, l2, r9, r11, r3, r7;
  logic [wbs_pkg::MID_W-1:0]   mid_c;
  logic [wbs_pkg::LOC_W:0]     diff_c;
  logic [wbs_pkg::LOC_W-1:0]   d_c;
  wbs_pkg::dir_t               dir_c;
  logic                        far_c;

  always_comb begin
    l_x    = wbs_pkg::CMP_W'(loc_r);
    r_x    = wbs_pkg::CMP_W'(row_bytes_r);
    l20    = (l_x << 4) + (l_x << 2);
    l10    = (l_x << 3) + (l_x << 1);
    l2     = l_x << 1;
    r9     = (r_x << 3) + r_x;
    r11    = (r_x << 3) + (r_x << 1) + r_x;
    r3     = (r_x << 1) + r_x;
    r7     = (r_x << 3) - r_x;
    mid_c  = row_bytes_r[wbs_pkg::ROW_W-1:1];
    diff_c = {1'b0, loc_r} - (wbs_pkg::LOC_W + 1)'(mid_c);
    d_c    = diff_c[wbs_pkg::LOC_W] ? wbs_pkg::LOC_W'(-diff_c) : diff_c[wbs_pkg::LOC_W-1:0];

    if (!found_r) begin
      dir_c = wbs_pkg::DIR_NONE;
    end else if ((l20 >= r9) && (l20 <= r11)) begin
      dir_c = wbs_pkg::DIR_CENTRE;
    end else if (l2 < r_x) begin
      dir_c = wbs_pkg::DIR_LEFT;
    end else if (l2 > r_x) begin
      dir_c = wbs_pkg::DIR_RIGHT;
    end else begin
      dir_c = wbs_pkg::DIR_NONE;
    end
    far_c = (l2 < r_x) ? (l10 < r3) : (l10 > r7);
  end

  // Command datapath.
  always_ff @(posedge clk) begin
    if (state_r == wbs_pkg::S_IDLE && in_acc && in_ch.last_in_frame) begin
      loc_r   <= snap.location;
      found_r <= snap.found;
    end
    if (state_r == wbs_pkg::S_PREP) begin
      d_r        <= d_c;
      mid_r      <= mid_c;
      zero_mid_r <= (mid_c == '0);
      dir_r      <= dir_c;
      far_r      <= far_c;
    end
    if (state_r == wbs_pkg::S_MUL) begin
      ang_prod_r <= wbs_pkg::PROD_W'(d_r) * wbs_pkg::PROD_W'(wbs_pkg::ANG_MUL);
      ang_den_r  <= wbs_pkg::MDEN_W'(mid_r) * wbs_pkg::MDEN_W'(wbs_pkg::ANG_DIV);
    end
    // With a zero midpoint the turn and the angular magnitude are both taken as zero.
    if (state_r == wbs_pkg::S_TURN_WAIT && div_rsp.done) begin
      turn_r <= zero_mid_r ? '0 : div_rsp.quo_sat;
    end
    if (state_r == wbs_pkg::S_ANG_WAIT && div_rsp.done) begin
      angm_r <= zero_mid_r ? '0 : div_rsp.quo_sat;
    end
  end

  // Output register: the command item stays here until it is taken.
  logic signed [wbs_pkg::SPD_W-1:0] lin_c, ang_c;
  logic signed [wbs_pkg::SPD_W-1:0] turn_s, angm_s;

  always_comb begin
    turn_s = $signed({1'b0, turn_r});
    angm_s = $signed({1'b0, angm_r});
    lin_c  = '0;
    ang_c  = '0;
    case (dir_r)
      wbs_pkg::DIR_CENTRE: begin
        lin_c = wbs_pkg::STRAIGHT_Q;
      end
      wbs_pkg::DIR_LEFT: begin
        lin_c = far_r ? '0 : turn_s;
        ang_c = angm_s;
      end
      wbs_pkg::DIR_RIGHT: begin
        lin_c = far_r ? '0 : turn_s;
        ang_c = -angm_s;
      end
      default: begin
        lin_c = '0;
        ang_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.linear_speed  <= lin_c;
      out_ch.angular_speed <= ang_c;
      out_ch.ball_seen     <= found_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  // A frame end always starts the command computation.
  a_frame_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_in_frame |=> state_r == wbs_pkg::S_PREP)
    else $error("frame end did not start the command computation");

  // A command item only appears after the load step.
  a_load_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == wbs_pkg::S_LOAD)
    else $error("command item appeared without a load step");

  // The divider is never restarted while it is still working.
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Without a white pixel both speeds are zero.
  a_no_ball_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ball_seen |->
      out_ch.linear_speed == '0 && out_ch.angular_speed == '0)
    else $error("motion commanded without a white pixel");

endmodule

FILE: src/wbs_tracker.sv
// ============================================================================
// White blob tracker
// Per-pixel run detection and running location, cleared at frame end.
// ============================================================================
module wbs_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  wbs_pkg::pix_t      pix,
  output wbs_pkg::trk_snap_t snap
);

  logic [wbs_pkg::LOC_W-1:0] loc_r, loc_nxt;
  logic                      found_r, found_nxt;
  logic                      in_run_r, in_run_nxt;
  logic                      skip_r, skip_nxt;

  logic                      active;
  logic                      white;
  logic                      run_now;
  logic                      run_end;
  logic [wbs_pkg::LOC_W-1:0] offset;
  logic [wbs_pkg::LOC_W:0]   loc_sum;

  always_comb begin
    active  = !skip_r &&
              (wbs_pkg::COL_CMP_W'(pix.column) < wbs_pkg::COL_CMP_W'(wbs_pkg::MAX_COLS));
    white   = (pix.red == wbs_pkg::CHAN_FULL) && (pix.green == wbs_pkg::CHAN_FULL) &&
              (pix.blue == wbs_pkg::CHAN_FULL);
    offset  = wbs_pkg::LOC_W'(pix.column) + (wbs_pkg::LOC_W'(pix.column) << 1);
    loc_sum = {1'b0, loc_r} + {1'b0, offset};
    run_now = in_run_r || (active && white);
    run_end = active && run_now && (pix.green != wbs_pkg::CHAN_FULL);

    loc_nxt    = (active && white) ? loc_sum[wbs_pkg::LOC_W:1] : loc_r;
    found_nxt  = found_r || (active && white);
    in_run_nxt = active ? (run_now && !run_end) : in_run_r;
    skip_nxt   = (skip_r || run_end) && !pix.last_in_row;

    // The command works on the state as it stands after this pixel.
    snap.location = loc_nxt;
    snap.found    = found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r    <= '0;
      found_r  <= 1'b0;
      in_run_r <= 1'b0;
      skip_r   <= 1'b0;
    end else if (accept) begin
      if (pix.last_in_frame) begin
        loc_r    <= '0;
        found_r  <= 1'b0;
        in_run_r <= 1'b0;
        skip_r   <= 1'b0;
      end else begin
        loc_r    <= loc_nxt;
        found_r  <= found_nxt;
        in_run_r <= in_run_nxt;
        skip_r   <= skip_nxt;
      end
    end
  end

endmodule

FILE: src/wbs_divider.sv
// ============================================================================
// Shared restoring divider
// One quotient bit per cycle; the quotient is saturated to 15 bits.
// ============================================================================
module wbs_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  wbs_pkg::div_req_t req,
  output wbs_pkg::div_rsp_t rsp
);

  logic [wbs_pkg::DIV_NUM_W-1:0] num_r, num_nxt;
  logic [wbs_pkg::DIV_DEN_W-1:0] den_r;
  logic [wbs_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [wbs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [wbs_pkg::DIV_DEN_W:0]   trial;
  logic [wbs_pkg::DIV_DEN_W:0]   diff;
  logic                          ge;

  always_comb begin
    trial   = {rem_r, num_r[wbs_pkg::DIV_NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    diff    = trial - {1'b0, den_r};
    rem_nxt = ge ? diff[wbs_pkg::DIV_DEN_W-1:0] : trial[wbs_pkg::DIV_DEN_W-1:0];
    num_nxt = {num_r[wbs_pkg::DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= wbs_pkg::DIV_CNT_W'(wbs_pkg::DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wbs_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.quo_sat = (|num_r[wbs_pkg::DIV_NUM_W-1:wbs_pkg::MAG_W]) ? wbs_pkg::SAT_MAX
                                                                     : num_r[wbs_pkg::MAG_W-1:0];

endmodule
